// File: src/tempo_synced_lfo_cutoff_core_defines.svh
// ----------------------------------------------------------------------------
// Tempo-synced LFO cutoff core: assertion macros
// Shared property shorthands. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TEMPO_SYNCED_LFO_CUTOFF_CORE_DEFINES_SVH
`define TEMPO_SYNCED_LFO_CUTOFF_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TSLC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TSLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tslc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo-synced LFO cutoff package
// Types, codes, rate tables, modulo helpers and the sine table.
// ----------------------------------------------------------------------------
package tslc_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_PHASE,
		ST_DEPTH,
		ST_EMIT
	} state_t;

	// what the shared multiplier works on
	typedef enum logic [1:0] {
		OP_SCALE,
		OP_PHASE,
		OP_DEPTH
	} mul_op_t;

	// sequencer to datapath control
	typedef struct packed {
		logic    mul_en;
		mul_op_t op;
		logic    emit;
	} ctrl_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_LFO_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_CUTOFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SELECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd4;

	// wave shape codes
	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
	localparam logic [2:0] WAVE_SAW_DOWN = 3'd2;
	localparam logic [2:0] WAVE_SQUARE   = 3'd3;

	// field widths
	localparam int BEAT_W    = 40;
	localparam int CUTOFF_W  = 7;
	localparam int DEPTH_W   = 7;
	localparam int SHAPE_W   = 3;
	localparam int RATE_W    = 4;
	localparam int PHASE_W   = 16;
	localparam int WAVE_W    = 17;
	localparam int NUM_W     = 4;
	localparam int DEN_W     = 5;
	localparam int KMOD_W    = 4;
	localparam int Y_W       = 20;
	localparam int RECIP_W   = 20;
	localparam int RECIP_SHIFT = 19;
	localparam int DPROD_W   = 24;
	localparam int MIX_W     = 25;

	localparam int RATE_ENTRIES = 16;

	// sine table
	localparam int SINE_DEPTH = 256;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam logic [63:0] Q30_PI = 64'd3373259426;

	typedef logic [WAVE_W-1:0] sine_rom_t [SINE_DEPTH];

	// period numerator by rate index
	function automatic logic [NUM_W-1:0] rate_num(input logic [RATE_W-1:0] r);
		logic [NUM_W-1:0] n;
		case (r)
			4'd5:    n = 4'd3;
			4'd6:    n = 4'd2;
			4'd8:    n = 4'd3;
			4'd9:    n = 4'd4;
			4'd10:   n = 4'd2;
			4'd11:   n = 4'd3;
			4'd12:   n = 4'd8;
			4'd13:   n = 4'd4;
			4'd14:   n = 4'd6;
			4'd15:   n = 4'd8;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

	// period denominator by rate index
	function automatic logic [DEN_W-1:0] rate_den(input logic [RATE_W-1:0] r);
		logic [DEN_W-1:0] d;
		case (r)
			4'd0:    d = 5'd16;
			4'd1:    d = 5'd8;
			4'd2:    d = 5'd4;
			4'd3:    d = 5'd3;
			4'd4:    d = 5'd2;
			4'd5:    d = 5'd4;
			4'd6:    d = 5'd3;
			4'd8:    d = 5'd2;
			4'd9:    d = 5'd3;
			4'd12:   d = 5'd3;
			default: d = 5'd1;
		endcase
		return d;
	endfunction

	// reciprocal of the denominator in Q19; exact for divide by three below 2^19
	function automatic logic [RECIP_W-1:0] den_recip(input logic [DEN_W-1:0] d);
		logic [RECIP_W-1:0] rc;
		case (d)
			5'd2:    rc = 20'd262144;
			5'd3:    rc = 20'd174763;
			5'd4:    rc = 20'd131072;
			5'd8:    rc = 20'd65536;
			5'd16:   rc = 20'd32768;
			default: rc = 20'd524288;
		endcase
		return rc;
	endfunction

	// x mod 3 by digit sums in base four
	function automatic logic [1:0] mod3_32(input logic [31:0] x);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = '0;
		for (int d = 0; d < 16; d++) begin
			s1 = s1 + 6'(x[2*d +: 2]);
		end
		s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
		s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
		return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
	endfunction

	// q mod den for den in {1,2,3,4,8,16}
	function automatic logic [KMOD_W-1:0] mod_den(input logic [31:0] q,
			input logic [DEN_W-1:0] d);
		logic [DEN_W-1:0] dm1;
		dm1 = d - 5'd1;
		if (d == 5'd3) begin
			return {2'b00, mod3_32(q)};
		end
		return q[KMOD_W-1:0] & dm1[KMOD_W-1:0];
	endfunction

	// Q30 sine by nine Taylor terms, truncating products
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 8; k++) begin
			term = (term * x2) >> 30;
			case (k)
				1:       term = term / 64'd6;
				2:       term = term / 64'd20;
				3:       term = term / 64'd42;
				4:       term = term / 64'd72;
				5:       term = term / 64'd110;
				6:       term = term / 64'd156;
				7:       term = term / 64'd210;
				default: term = term / 64'd272;
			endcase
			if (k % 2 == 1) begin
				acc = (acc >= term) ? acc - term : 64'd0;
			end else begin
				acc = acc + term;
			end
		end
		return acc;
	endfunction

	// sin^2(pi*i/D) in Q1.16, built at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] j;
		logic [63:0] ang;
		logic [63:0] s;
		logic [63:0] sq;
		logic [63:0] v;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			j = (i <= SINE_DEPTH - i) ? 64'(i) : 64'(SINE_DEPTH - i);
			ang = (Q30_PI * j + 64'(SINE_DEPTH / 2)) / SINE_DEPTH;
			s = sin_q30(ang);
			sq = (s * s) >> 30;
			v = (sq + 64'd8192) >> 14;
			rom[i] = (v > 64'd65536) ? 17'h10000 : v[WAVE_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: src/tslc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiply with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module tslc_mul #(
	parameter int A_W = 21,
	parameter int B_W = 21
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] prod_q
);

	// product register; payload only, no reset
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// File: src/tslc_wave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave shaper
// Maps a Q0.16 phase to a Q1.16 wave value for the selected shape.
// ----------------------------------------------------------------------------
module tslc_wave (
	input  logic [tslc_pkg::SHAPE_W-1:0] shape,
	input  logic [tslc_pkg::PHASE_W-1:0] phase,
	output logic [tslc_pkg::WAVE_W-1:0]  wave
);
	import tslc_pkg::*;

	logic [WAVE_W-1:0] fall;

	// distance to the top of the cycle
	assign fall = 17'h10000 - {1'b0, phase};

	always_comb begin
		case (shape)
			WAVE_SINE:     wave = SINE_ROM[phase[PHASE_W-1 -: SINE_IDX_W]];
			WAVE_TRIANGLE: wave = phase[PHASE_W-1] ? {fall[PHASE_W-1:0], 1'b0}
				: {phase, 1'b0};
			WAVE_SAW_DOWN: wave = fall;
			WAVE_SQUARE:   wave = phase[PHASE_W-1] ? 17'h10000 : 17'h00000;
			default:       wave = 17'h08000;
		endcase
	end

endmodule

// File: src/tslc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer
// Steps a modulated word through the three passes of the shared multiplier.
// ----------------------------------------------------------------------------
module tslc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            lfo_en,
	input  logic            tempo_valid,
	input  logic            base_repeat,
	input  logic            out_free,
	output logic            ready,
	output tslc_pkg::ctrl_t ctrl
);
	import tslc_pkg::*;

	`include "tempo_synced_lfo_cutoff_core_defines.svh"

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (lfo_en) begin
						state_nxt = tempo_valid ? ST_SCALE : ST_IDLE;
					end else begin
						state_nxt = base_repeat ? ST_IDLE : ST_EMIT;
					end
				end
			end
			ST_SCALE: state_nxt = ST_PHASE;
			ST_PHASE: state_nxt = ST_DEPTH;
			ST_DEPTH: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ready = 1'b0;
		ctrl.mul_en = 1'b0;
		ctrl.op = OP_SCALE;
		ctrl.emit = 1'b0;
		case (state_q)
			ST_IDLE:  ready = 1'b1;
			ST_SCALE: begin
				ctrl.mul_en = 1'b1;
				ctrl.op = OP_SCALE;
			end
			ST_PHASE: begin
				ctrl.mul_en = 1'b1;
				ctrl.op = OP_PHASE;
			end
			ST_DEPTH: begin
				ctrl.mul_en = 1'b1;
				ctrl.op = OP_DEPTH;
			end
			ST_EMIT:  ctrl.emit = out_free;
			default:  ready = 1'b0;
		endcase
	end

	`TSLC_ASSERT_NEXT(a_mod_start, in_fire && lfo_en && tempo_valid, state_q == ST_SCALE, "modulated word did not start the multiply passes")
	`TSLC_ASSERT_NEXT(a_depth_to_emit, state_q == ST_DEPTH, state_q == ST_EMIT, "depth pass not followed by emit")
	`TSLC_ASSERT_NEXT(a_emit_hold, state_q == ST_EMIT && !out_free, state_q == ST_EMIT, "result dropped while output busy")

endmodule

// File: src/tempo_synced_lfo_cutoff_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo-synced LFO cutoff core
// Modulates a filter cutoff with a tempo-locked LFO, or resends the base
// cutoff when modulation is off and the base value has changed.
//
//  channel  | dir | tdata                       | tuser
//  s_axis   | in  | [39:0] beat_position        | [0] tempo_valid
//  m_axis   | out | [6:0] cutoff, [7] zero      | [0] from_modulator
//  cfg      | in  | cfg_index selects register, cfg_wdata[6:0] value
//
// A modulated word goes through three passes of the one shared multiplier
// (beat scale, phase reciprocal, depth) and an emit state before the next
// word is accepted. A base resend goes through the emit state alone, and a
// word with no result returns straight to idle. The result sits in an output
// register, so a new word is taken while it waits; emit waits only if that
// register is still full. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module tempo_synced_lfo_cutoff_core #(
	parameter int BEAT_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [39:0] beat_position
	input  logic [0:0]  s_axis_tuser,   // [0] tempo_valid
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] cutoff, [7] zero
	output logic [0:0]  m_axis_tuser,   // [0] from_modulator
	// configuration writes
	input  logic                               cfg_we,
	input  logic [tslc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tslc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import tslc_pkg::*;

	`include "tempo_synced_lfo_cutoff_core_defines.svh"

	localparam int F      = BEAT_FRAC_BITS;
	localparam int A_W    = F + KMOD_W;
	localparam int T_W    = F + DEN_W;
	localparam int UMAX_W = (A_W > Y_W) ? A_W : Y_W;
	localparam int OPA_W  = UMAX_W + 1;
	localparam int OPB_W  = RECIP_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;

	// configuration registers
	logic                 lfo_en_q;
	logic [CUTOFF_W-1:0]  base_cutoff_q;
	logic [SHAPE_W-1:0]   wave_shape_q;
	logic [RATE_W-1:0]    rate_sel_q;
	logic signed [DEPTH_W-1:0] depth_q;

	// last base value sent
	logic                 sent_vld_q;
	logic [CUTOFF_W-1:0]  sent_val_q;

	// word state
	logic [A_W-1:0]       a_q;
	logic                 mod_q;

	// output register
	logic                 out_vld_q;
	logic [CUTOFF_W-1:0]  out_cutoff_q;
	logic                 out_mod_q;

	ctrl_t                ctrl;
	logic                 in_fire;
	logic                 out_free;
	logic                 base_repeat;

	logic [NUM_W-1:0]     num;
	logic [DEN_W-1:0]     den;
	logic [RECIP_W-1:0]   recip;
	logic [KMOD_W-1:0]    k_in;
	logic [A_W-1:0]       a_in;
	logic [T_W-1:0]       t_scaled;
	logic [KMOD_W-1:0]    k_t;
	logic [A_W+PHASE_W-1:0] m_ext;
	logic [Y_W-1:0]       y_val;
	logic [PHASE_W-1:0]   phase;
	logic [WAVE_W-1:0]    wave;
	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DPROD_W-1:0] dprod;
	logic signed [MIX_W-1:0] mix;
	logic [MIX_W-1:0]     mix_rnd;
	logic [CUTOFF_W-1:0]  mod_cutoff;

	assign in_fire     = s_axis_tvalid && s_axis_tready;
	assign out_free    = !out_vld_q || m_axis_tready;
	assign base_repeat = sent_vld_q && (sent_val_q == base_cutoff_q);

	// rate tables
	assign num   = rate_num(rate_sel_q);
	assign den   = rate_den(rate_sel_q);
	assign recip = den_recip(den);

	// beat reduced modulo the period span: integer part mod den, fraction kept
	assign k_in = mod_den(32'(s_axis_tdata[BEAT_W-1:F]), den);
	assign a_in = {k_in, s_axis_tdata[F-1:0]};

	// scaled beat reduced again, then moved to a Q16 numerator
	assign t_scaled = prod_q[T_W-1:0];
	assign k_t      = mod_den(32'(t_scaled[T_W-1:F]), den);
	assign m_ext    = {k_t, t_scaled[F-1:0], {PHASE_W{1'b0}}};
	assign y_val    = m_ext[F+Y_W-1:F];

	// phase after the reciprocal pass
	assign phase = prod_q[RECIP_SHIFT +: PHASE_W];

	tslc_wave u_wave (
		.shape (wave_shape_q),
		.phase (phase),
		.wave  (wave)
	);

	// operand select for the shared multiplier
	always_comb begin
		case (ctrl.op)
			OP_SCALE: begin
				opa = signed'(OPA_W'(a_q));
				opb = signed'(OPB_W'(num));
			end
			OP_PHASE: begin
				opa = signed'(OPA_W'(y_val));
				opb = signed'(OPB_W'(recip));
			end
			OP_DEPTH: begin
				opa = signed'(OPA_W'(wave));
				opb = OPB_W'(depth_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	tslc_mul #(
		.A_W (OPA_W),
		.B_W (OPB_W)
	) u_mul (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.a      (opa),
		.b      (opb),
		.prod_q (prod_q)
	);

	tslc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.lfo_en      (lfo_en_q),
		.tempo_valid (s_axis_tuser[0]),
		.base_repeat (base_repeat),
		.out_free    (out_free),
		.ready       (s_axis_tready),
		.ctrl        (ctrl)
	);

	// base plus scaled wave, round half up (value is non-negative), clamp
	assign dprod   = prod_q[DPROD_W-1:0];
	assign mix     = signed'({2'b00, base_cutoff_q, {PHASE_W{1'b0}}}) + MIX_W'(dprod);
	assign mix_rnd = unsigned'(mix) + MIX_W'(32768);

	always_comb begin
		if (mix[MIX_W-1]) begin
			mod_cutoff = '0;
		end else if (mix_rnd[PHASE_W+CUTOFF_W]) begin
			mod_cutoff = '1;
		end else begin
			mod_cutoff = mix_rnd[PHASE_W +: CUTOFF_W];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_en_q      <= 1'b0;
			base_cutoff_q <= 7'd64;
			wave_shape_q  <= WAVE_SINE;
			rate_sel_q    <= 4'd4;
			depth_q       <= 7'sd63;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LFO_ENABLED: lfo_en_q      <= cfg_wdata[0];
				REG_BASE_CUTOFF: base_cutoff_q <= cfg_wdata[CUTOFF_W-1:0];
				REG_WAVE_SHAPE:  wave_shape_q  <= cfg_wdata[SHAPE_W-1:0];
				REG_RATE_SELECT: rate_sel_q    <= cfg_wdata[RATE_W-1:0];
				REG_DEPTH:       depth_q       <= signed'(cfg_wdata[DEPTH_W-1:0]);
				default: ;
			endcase
		end
	end

	// last-sent base marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_vld_q <= 1'b0;
		end else if (in_fire && lfo_en_q && s_axis_tuser[0]) begin
			sent_vld_q <= 1'b0;
		end else if (ctrl.emit && !mod_q) begin
			sent_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && !mod_q) begin
			sent_val_q <= base_cutoff_q;
		end
	end

	// word capture at acceptance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_q   <= a_in;
			mod_q <= lfo_en_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_cutoff_q <= mod_q ? mod_cutoff : base_cutoff_q;
			out_mod_q    <= mod_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_cutoff_q};
	assign m_axis_tuser  = out_mod_q;

	`TSLC_ASSERT_SAME(a_emit_slot_free, ctrl.emit, !out_vld_q || m_axis_tready,
		"emit overwrote a waiting word")
	`TSLC_ASSERT_NEXT(a_mod_clears_sent, in_fire && lfo_en_q && s_axis_tuser[0],
		!sent_vld_q, "enabled word left the last-sent marker set")
	`TSLC_ASSERT_NEXT(a_resend_records, ctrl.emit && !mod_q,
		sent_vld_q && (sent_val_q == $past(base_cutoff_q)), "base resend not recorded")

endmodule

// File: sim/lfo_cutoff_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFO cutoff checker
// Follows the register writes and every accepted beat word, works out the
// cutoff word each one should cause, and compares the result words in order.
// ----------------------------------------------------------------------------
module lfo_cutoff_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [tslc_pkg::BEAT_W-1:0]         s_axis_tdata,   // [39:0] beat_position
	input  logic [0:0]                          s_axis_tuser,   // [0] tempo_valid
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [7:0]                          m_axis_tdata,   // [6:0] cutoff, [7] zero
	input  logic [0:0]                          m_axis_tuser,   // [0] from_modulator
	input  logic                                cfg_we,
	input  logic [tslc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tslc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output int                                  errors,
	output int                                  pending
);
	import tslc_pkg::*;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam int LUT_DEPTH = 256;
	localparam int FRAC_BITS = 16;
	localparam logic [7:0] NOTHING_SENT = 8'hFF;

	typedef struct packed {
		logic [CUTOFF_W-1:0] cutoff;
		logic                from_mod;
	} cutoff_word_t;

	logic [WAVE_W-1:0] sin_sq_lut [LUT_DEPTH];

	// register copies and resend marker
	logic                      en_q;
	logic [CUTOFF_W-1:0]       base_q;
	logic [SHAPE_W-1:0]        shape_q;
	logic [RATE_W-1:0]         rate_q;
	logic signed [DEPTH_W-1:0] depth_q;
	logic [7:0]                last_base_q;

	cutoff_word_t cutoff_due_q [$];

	// Q30 sine, nine Taylor terms, products truncated
	function automatic logic [63:0] taylor_sin(input logic [63:0] x);
		logic [63:0] x_sq;
		logic [63:0] term;
		logic [63:0] sum;
		x_sq = (x * x) >> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// sin^2 table, angle folded about the half-way entry
	initial begin : build_lut
		logic [63:0] fold;
		logic [63:0] angle;
		logic [63:0] s;
		logic [63:0] sq;
		logic [63:0] lvl;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			fold = (i <= LUT_DEPTH - i) ? 64'(i) : 64'(LUT_DEPTH - i);
			angle = (PI_Q30 * fold + 64'(LUT_DEPTH / 2)) / 64'(LUT_DEPTH);
			s = taylor_sin(angle);
			sq = (s * s) >> 30;
			lvl = (sq + 64'd8192) >> 14;
			sin_sq_lut[i] = (lvl > 64'd65536) ? 17'h10000 : lvl[WAVE_W-1:0];
		end
	end

	// reciprocal period as num/den, 16 beats down to 1/8
	function automatic void period_ratio(input logic [RATE_W-1:0] sel,
			output int unsigned num, output int unsigned den);
		num = 1;
		den = 1;
		case (sel)
			4'd0:  den = 16;
			4'd1:  den = 8;
			4'd2:  den = 4;
			4'd3:  den = 3;
			4'd4:  den = 2;
			4'd5:  begin num = 3; den = 4; end
			4'd6:  begin num = 2; den = 3; end
			4'd8:  begin num = 3; den = 2; end
			4'd9:  begin num = 4; den = 3; end
			4'd10: num = 2;
			4'd11: num = 3;
			4'd12: begin num = 8; den = 3; end
			4'd13: num = 4;
			4'd14: num = 6;
			4'd15: num = 8;
			default: ;
		endcase
	endfunction

	// modulated cutoff for one beat position under the current settings
	function automatic logic [CUTOFF_W-1:0] modulated_cutoff(input logic [BEAT_W-1:0] beat);
		int unsigned num;
		int unsigned den;
		logic [63:0] span;
		logic [63:0] rem;
		logic [63:0] ph;
		logic [WAVE_W-1:0] wave;
		longint mix;
		period_ratio(rate_q, num, den);
		span = 64'(den) << FRAC_BITS;
		rem = (64'(beat) * 64'(num)) % span;
		ph = (rem << 16) / span;
		case (shape_q)
			WAVE_SINE:     wave = sin_sq_lut[8'((ph * LUT_DEPTH) >> 16)];
			WAVE_TRIANGLE: wave = (ph < 64'd32768) ? 17'(2 * ph)
				: 17'(2 * (64'd65536 - ph));
			WAVE_SAW_DOWN: wave = 17'(64'd65536 - ph);
			WAVE_SQUARE:   wave = (ph < 64'd32768) ? 17'd0 : 17'h10000;
			default:       wave = 17'h08000;
		endcase
		mix = longint'(base_q) * 65536 + longint'(wave) * longint'(depth_q);
		if (mix < 0) begin
			return '0;
		end
		mix = (mix + 32768) >>> 16;
		return (mix > 127) ? 7'd127 : 7'(mix);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		cutoff_word_t want;
		cutoff_word_t got;
		int bad;
		if (!arst_n) begin
			en_q <= 1'b0;
			base_q <= 7'd64;
			shape_q <= WAVE_SINE;
			rate_q <= 4'd4;
			depth_q <= 7'sd63;
			last_base_q <= NOTHING_SENT;
			cutoff_due_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			bad = 0;

			// result word against the oldest expectation; unknown bits count as wrong
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{cutoff: m_axis_tdata[CUTOFF_W-1:0], from_mod: m_axis_tuser[0]};
				if (cutoff_due_q.size() == 0) begin
					$display("%0t: unexpected word cutoff=%0d from_modulator=%0b",
						$time, got.cutoff, got.from_mod);
					bad++;
				end else begin
					want = cutoff_due_q.pop_front();
					if (got !== want || m_axis_tdata[7] !== 1'b0) begin
						$display({"%0t: mismatch expected cutoff=%0d from_modulator=%0b",
							" pad=0, got cutoff=%0d from_modulator=%0b pad=%0b"},
							$time, want.cutoff, want.from_mod, got.cutoff, got.from_mod,
							m_axis_tdata[7]);
						bad++;
					end
				end
			end

			// accepted beat word
			if (s_axis_tvalid && s_axis_tready) begin
				if (en_q) begin
					if (s_axis_tuser[0]) begin
						cutoff_due_q.push_back('{cutoff: modulated_cutoff(s_axis_tdata),
							from_mod: 1'b1});
						last_base_q <= NOTHING_SENT;
					end
				end else if ({1'b0, base_q} != last_base_q) begin
					cutoff_due_q.push_back('{cutoff: base_q, from_mod: 1'b0});
					last_base_q <= {1'b0, base_q};
				end
			end

			// register writes, values masked to width
			if (cfg_we) begin
				case (cfg_index)
					REG_LFO_ENABLED: en_q <= cfg_wdata[0];
					REG_BASE_CUTOFF: base_q <= cfg_wdata[CUTOFF_W-1:0];
					REG_WAVE_SHAPE:  shape_q <= cfg_wdata[SHAPE_W-1:0];
					REG_RATE_SELECT: rate_q <= cfg_wdata[RATE_W-1:0];
					REG_DEPTH:       depth_q <= cfg_wdata[DEPTH_W-1:0];
					default: ;
				endcase
			end

			errors <= errors + bad;
			pending <= cutoff_due_q.size();
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo-synced LFO cutoff testbench
// Drives beat words and register settings into the core, with random gaps on
// both streams, and leaves the checking to the cutoff checker beside it.
// ----------------------------------------------------------------------------
module testbench;
	import tslc_pkg::*;

	localparam int ITEM_TARGET = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam logic [BEAT_W-1:0] BEAT_MAX = '1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic [BEAT_W-1:0]      s_axis_tdata = '0;   // [39:0] beat_position
	logic [0:0]             s_axis_tuser = '0;   // [0] tempo_valid
	logic                   m_axis_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	wire                    s_axis_tready;
	wire                    m_axis_tvalid;
	wire [7:0]              m_axis_tdata;        // [6:0] cutoff, [7] zero
	wire [0:0]              m_axis_tuser;        // [0] from_modulator

	int errors;
	int pending;
	bit calm = 1'b0;
	int sent = 0;

	tempo_synced_lfo_cutoff_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	lfo_cutoff_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side back-pressure, off during the calm stretch
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 33);
	end

	// give up after a long spell with no word moving
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("DONE: errors detected");
		$finish;
	end

	// all five registers, spare bits filled at random, sometimes a stray index
	task automatic apply_config(input logic en, input logic [6:0] base,
			input logic [2:0] shape, input logic [3:0] rate, input logic [6:0] depth);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_DATA_W-1:0] val [6];
		int n;
		idx[0] = REG_LFO_ENABLED; val[0] = {6'($urandom), en};
		idx[1] = REG_BASE_CUTOFF; val[1] = base;
		idx[2] = REG_WAVE_SHAPE;  val[2] = {4'($urandom), shape};
		idx[3] = REG_RATE_SELECT; val[3] = {3'($urandom), rate};
		idx[4] = REG_DEPTH;       val[4] = depth;
		n = 5;
		if ($urandom_range(1) == 1) begin
			idx[5] = CFG_IDX_W'($urandom_range(int'(REG_DEPTH) + 1, 7));
			val[5] = CFG_DATA_W'($urandom);
			n = 6;
		end
		for (int k = 0; k < n; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= val[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// one beat word; valid stays up into the next word unless a gap is drawn
	task automatic send_word(input logic [BEAT_W-1:0] beat, input logic tempo_ok);
		bit rdy;
		while (!calm && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		s_axis_tuser <= tempo_ok;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// wait for every expected word, then let the core go quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// positions at or next to period edges and the top of the range
	function automatic logic [BEAT_W-1:0] boundary_beat();
		logic [BEAT_W-1:0] b;
		case ($urandom_range(3))
			0:       b = '0;
			1:       b = BEAT_MAX - BEAT_W'($urandom_range(3));
			default: b = (BEAT_W'($urandom_range(1 << 16)) << $urandom_range(10, 20))
					+ BEAT_W'($urandom_range(2)) - BEAT_W'(1);
		endcase
		return b;
	endfunction

	initial begin
		logic en;
		logic [6:0] base;
		logic [2:0] shape;
		logic [6:0] depth;
		logic ok;
		logic [BEAT_W-1:0] beat;
		logic [BEAT_W-1:0] stride;
		int n;
		int mode;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: disabled, first word resends base, repeat is silent
		send_word('0, 1'b1);
		send_word(BEAT_MAX, 1'b0);
		drain();

		// base change with a bad tempo still resends
		apply_config(1'b0, 7'd0, WAVE_SINE, 4'd4, 7'd63);
		send_word(BEAT_MAX, 1'b0);
		drain();

		// sine over the slowest period, peak at half period
		apply_config(1'b1, 7'd127, WAVE_SINE, 4'd0, 7'd63);
		send_word('0, 1'b1);
		send_word(BEAT_MAX, 1'b1);
		send_word(40'h00_0008_0000, 1'b1);
		send_word(40'd123, 1'b0);
		drain();

		// triangle at the fastest rate, most negative depth
		apply_config(1'b1, 7'd0, WAVE_TRIANGLE, 4'd15, 7'h40);
		send_word(40'h1000, 1'b1);
		send_word(40'h0800, 1'b1);
		send_word(BEAT_MAX, 1'b1);
		drain();

		// saw down on a period of three beats
		apply_config(1'b1, 7'd64, WAVE_SAW_DOWN, 4'd3, 7'd63);
		send_word(40'h1_0000, 1'b1);
		send_word(40'h2_0000, 1'b1);
		send_word(40'h3_0000, 1'b1);
		drain();

		// square clamping at the top
		apply_config(1'b1, 7'd127, WAVE_SQUARE, 4'd11, 7'd63);
		send_word(40'h5555, 1'b1);
		send_word(40'hAAAB, 1'b1);
		drain();

		// constant-half shape clamping at the bottom
		apply_config(1'b1, 7'd10, 3'd7, 4'd7, 7'h40);
		send_word(BEAT_W'({$urandom, $urandom}), 1'b1);
		drain();

		// back to disabled: marker was cleared, so same base goes out once
		apply_config(1'b0, 7'd10, WAVE_SINE, 4'd7, 7'h40);
		send_word(40'd5, 1'b1);
		send_word(40'd6, 1'b1);
		drain();

		// random settings, each followed by a run of words
		while (sent < ITEM_TARGET) begin
			calm <= (sent >= 250 && sent < 350);
			en = ($urandom_range(9) < 8);
			case ($urandom_range(4))
				0:       base = 7'd0;
				1:       base = 7'd127;
				default: base = 7'($urandom);
			endcase
			shape = ($urandom_range(3) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
			case ($urandom_range(4))
				0:       depth = 7'h40;
				1:       depth = 7'h3F;
				default: depth = 7'($urandom);
			endcase
			apply_config(en, base, shape, 4'($urandom), depth);

			n = en ? $urandom_range(10, 40) : $urandom_range(2, 8);
			mode = $urandom_range(99);
			beat = BEAT_W'({$urandom, $urandom});
			stride = BEAT_W'($urandom_range(1, 1 << $urandom_range(8, 20)));
			for (int k = 0; k < n; k++) begin
				if (mode < 60) begin
					beat = beat + stride;
				end else if (mode < 85) begin
					beat = BEAT_W'({$urandom, $urandom});
				end else begin
					beat = boundary_beat();
				end
				ok = ($urandom_range(9) != 0);
				send_word(beat, ok);
				if (ok || !en) begin
					sent++;
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
